// ===== rtl/cqf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqf_pkg
// Types and fixed widths shared by the ring-buffer queue modules.
// ----------------------------------------------------------------------------
package cqf_pkg;

   localparam int CMD_W    = 3;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQUEUE  = 3'd0,
      CMD_DEQUEUE  = 3'd1,
      CMD_PEEK     = 3'd2,
      CMD_CLEAR    = 3'd3,
      CMD_TRAVERSE = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_LOAD = 1'b1
   } state_type;

endpackage

// ===== rtl/cqf_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqf_mem
// Slot storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cqf_mem #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic signed [cqf_pkg::DATA_W-1:0]   wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic signed [cqf_pkg::DATA_W-1:0]   rd_data
);

   logic signed [cqf_pkg::DATA_W-1:0] slot_mem [DEPTH];
   logic signed [cqf_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cqf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqf_ctrl
// Head/tail pointers, command sequencer and result output register.
// ----------------------------------------------------------------------------
module cqf_ctrl #(
   parameter int SLOTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cqf_pkg::CMD_W-1:0]           req_cmd,
   input  logic signed [cqf_pkg::DATA_W-1:0]   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cqf_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [cqf_pkg::DATA_W-1:0]   rsp_value,
   output logic [cqf_pkg::FILL_W-1:0]          rsp_fill,
   output logic                                rsp_empty,
   output logic                                rsp_last,
   output logic                                mem_wr_en,
   output logic [$clog2(SLOTS)-1:0]            mem_wr_addr,
   output logic signed [cqf_pkg::DATA_W-1:0]   mem_wr_data,
   output logic                                mem_rd_en,
   output logic [$clog2(SLOTS)-1:0]            mem_rd_addr,
   input  logic signed [cqf_pkg::DATA_W-1:0]   mem_rd_data
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int FW    = (IDX_W > cqf_pkg::FILL_W) ? IDX_W : cqf_pkg::FILL_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [IDX_W:0]   SLOTS_X  = (IDX_W + 1)'(SLOTS);

   cqf_pkg::state_type  state_ff, state_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [IDX_W-1:0]    walk_ff, walk_in;
   cqf_pkg::status_type pend_status_ff, pend_status_in;
   logic                pend_last_ff, pend_last_in;
   logic                pend_mem_ff, pend_mem_in;
   logic                pend_walk_ff, pend_walk_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [cqf_pkg::STATUS_W-1:0]        rsp_status_ff;
   logic signed [cqf_pkg::DATA_W-1:0]   rsp_value_ff;
   logic [cqf_pkg::FILL_W-1:0]          rsp_fill_ff;
   logic                                rsp_empty_ff;
   logic                                rsp_last_ff;

   logic             accept;
   logic             out_free;
   logic             load;
   logic             walk_more;
   logic             q_empty;
   logic             q_full;
   logic [IDX_W-1:0] head_next;
   logic [IDX_W-1:0] tail_next;
   logic [IDX_W-1:0] walk_next;
   logic [IDX_W:0]   fill_wide;
   logic [FW-1:0]    fill_ext;

   function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   assign head_next = wrap_next(head_ff);
   assign tail_next = wrap_next(tail_ff);
   assign walk_next = wrap_next(walk_ff);
   assign q_empty   = (head_ff == tail_ff);
   assign q_full    = (tail_next == head_ff);

   assign fill_wide = (tail_ff >= head_ff) ?
                      ({1'b0, tail_ff} - {1'b0, head_ff}) :
                      ({1'b0, tail_ff} + SLOTS_X - {1'b0, head_ff});
   assign fill_ext  = FW'(fill_wide);

   assign req_ready = (state_ff == cqf_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load      = (state_ff == cqf_pkg::ST_LOAD) && out_free;
   assign walk_more = pend_walk_ff && !pend_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cqf_pkg::ST_IDLE: begin
            if (accept) begin
               case (cqf_pkg::cmd_type'(req_cmd))
                  cqf_pkg::CMD_ENQUEUE,
                  cqf_pkg::CMD_DEQUEUE,
                  cqf_pkg::CMD_PEEK,
                  cqf_pkg::CMD_CLEAR,
                  cqf_pkg::CMD_TRAVERSE: state_in = cqf_pkg::ST_LOAD;
                  default:               state_in = cqf_pkg::ST_IDLE;
               endcase
            end
         end
         cqf_pkg::ST_LOAD: begin
            if (load && !walk_more) begin
               state_in = cqf_pkg::ST_IDLE;
            end
         end
         default: state_in = cqf_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      walk_in        = walk_ff;
      pend_status_in = pend_status_ff;
      pend_last_in   = pend_last_ff;
      pend_mem_in    = pend_mem_ff;
      pend_walk_in   = pend_walk_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = tail_ff;
      mem_wr_data    = req_data;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = head_ff;
      case (state_ff)
         cqf_pkg::ST_IDLE: begin
            if (accept) begin
               pend_status_in = cqf_pkg::STATUS_OK;
               pend_last_in   = 1'b1;
               pend_mem_in    = 1'b0;
               pend_walk_in   = 1'b0;
               case (cqf_pkg::cmd_type'(req_cmd))
                  cqf_pkg::CMD_ENQUEUE: begin
                     if (q_full) begin
                        pend_status_in = cqf_pkg::STATUS_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        tail_in   = tail_next;
                     end
                  end
                  cqf_pkg::CMD_DEQUEUE: begin
                     if (q_empty) begin
                        pend_status_in = cqf_pkg::STATUS_EMPTY;
                     end else begin
                        mem_rd_en   = 1'b1;
                        pend_mem_in = 1'b1;
                        head_in     = head_next;
                     end
                  end
                  cqf_pkg::CMD_PEEK: begin
                     if (q_empty) begin
                        pend_status_in = cqf_pkg::STATUS_EMPTY;
                     end else begin
                        mem_rd_en   = 1'b1;
                        pend_mem_in = 1'b1;
                     end
                  end
                  cqf_pkg::CMD_CLEAR: begin
                     tail_in = head_ff;
                  end
                  cqf_pkg::CMD_TRAVERSE: begin
                     if (q_empty) begin
                        pend_status_in = cqf_pkg::STATUS_EMPTY;
                     end else begin
                        mem_rd_en    = 1'b1;
                        pend_mem_in  = 1'b1;
                        pend_walk_in = 1'b1;
                        pend_last_in = (head_next == tail_ff);
                        walk_in      = head_next;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         cqf_pkg::ST_LOAD: begin
            // advance the walk once the current beat is loaded
            if (load && walk_more) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = walk_ff;
               walk_in      = walk_next;
               pend_last_in = (walk_next == tail_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cqf_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff        <= walk_in;
      pend_status_ff <= pend_status_in;
      pend_last_ff   <= pend_last_in;
      pend_mem_ff    <= pend_mem_in;
      pend_walk_ff   <= pend_walk_in;
      if (load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_value_ff  <= pend_mem_ff ? mem_rd_data : '0;
         rsp_fill_ff   <= fill_ext[cqf_pkg::FILL_W-1:0];
         rsp_empty_ff  <= q_empty;
         rsp_last_ff   <= pend_last_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_fill   = rsp_fill_ff;
   assign rsp_empty  = rsp_empty_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ===== rtl/circular_queue_fifo_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_fifo_top
// Ring-buffer queue of signed 32-bit words with enqueue, dequeue, peek,
// clear and traverse commands; one slot stays free.
//
//   channel | dir | beat contents
//   req     | in  | tuser: command[2:0]; tdata: data_in[31:0]
//   rsp     | out | tuser: status[1:0], is_empty[2]; tdata: item_value[31:0],
//           |     | fill_count[35:32]; tlast: last_item
//
// A command is accepted, then its result is loaded into the result register;
// the slot read issued at accept has its data ready for that load.
// Traverse of N items gives N result beats, one memory read per beat.
// A stalled result holds the sequencer in its load step.
// Reset empties the queue; slot contents are not cleared.
// ----------------------------------------------------------------------------
module circular_queue_fifo_top #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // command[2:0]
   input  logic [31:0] req_tdata,   // data_in[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,   // status[1:0], is_empty[2]
   output logic [39:0] rsp_tdata,   // item_value[31:0], fill_count[35:32], zero
   output logic        rsp_tlast
);

   localparam int IDX_W = $clog2(SLOTS);

   logic                                mem_wr_en;
   logic [IDX_W-1:0]                    mem_wr_addr;
   logic signed [cqf_pkg::DATA_W-1:0]   mem_wr_data;
   logic                                mem_rd_en;
   logic [IDX_W-1:0]                    mem_rd_addr;
   logic signed [cqf_pkg::DATA_W-1:0]   mem_rd_data;
   logic [cqf_pkg::STATUS_W-1:0]        rsp_status;
   logic signed [cqf_pkg::DATA_W-1:0]   rsp_value;
   logic [cqf_pkg::FILL_W-1:0]          rsp_fill;
   logic                                rsp_empty;

   cqf_mem #(
      .DEPTH (SLOTS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   cqf_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_tuser),
      .req_data    (req_tdata),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_status),
      .rsp_value   (rsp_value),
      .rsp_fill    (rsp_fill),
      .rsp_empty   (rsp_empty),
      .rsp_last    (rsp_tlast),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   assign rsp_tuser = {rsp_empty, rsp_status};
   assign rsp_tdata = {4'b0000, rsp_fill, rsp_value};

endmodule

// ===== dv/circular_queue_fifo_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_fifo_checker
// Watches the command and response streams of the ring-buffer queue. It
// keeps its own copy of the slots and the head and tail indexes, works out
// the response beats of every accepted command and compares each response
// beat with the oldest beat still awaited.
// ----------------------------------------------------------------------------
module circular_queue_fifo_checker #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [2:0]  req_tuser,   // command[2:0]
   input  logic [31:0] req_tdata,   // data_in[31:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [2:0]  rsp_tuser,   // status[1:0], is_empty[2]
   input  logic [39:0] rsp_tdata,   // item_value[31:0], fill_count[35:32], zero
   input  logic        rsp_tlast,
   output int          error_count,
   output int          pending_count,
   output int          beat_count
);

   localparam int CMD_W    = cqf_pkg::CMD_W;
   localparam int DATA_W   = cqf_pkg::DATA_W;
   localparam int STATUS_W = cqf_pkg::STATUS_W;
   localparam int FILL_W   = cqf_pkg::FILL_W;

   typedef struct packed {
      cqf_pkg::status_type status;
      logic [DATA_W-1:0]   value;
      logic [FILL_W-1:0]   fill;
      logic                empty;
      logic                last;
   } rsp_beat_type;

   logic [DATA_W-1:0] slot_mem [SLOTS];
   int unsigned       head_idx = 0;
   int unsigned       tail_idx = 0;
   rsp_beat_type      awaited_rsp [$];
   rsp_beat_type      want_beat;
   rsp_beat_type      got_beat;
   int                mismatches = 0;
   int                beats_seen = 0;

   function automatic int unsigned next_idx(input int unsigned idx);
      return (idx + 1) % SLOTS;
   endfunction

   task automatic push_beat(input cqf_pkg::status_type st,
                            input logic [DATA_W-1:0] value, input logic last);
      rsp_beat_type beat;
      int unsigned  level;
      level        = (tail_idx + SLOTS - head_idx) % SLOTS;
      beat.status  = st;
      beat.value   = value;
      beat.fill    = level[FILL_W-1:0];
      beat.empty   = (level == 0);
      beat.last    = last;
      awaited_rsp.push_back(beat);
   endtask

   task automatic run_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] data);
      int unsigned idx;
      logic        was_empty;
      was_empty = (head_idx == tail_idx);
      case (cmd)
         cqf_pkg::CMD_ENQUEUE: begin
            if (next_idx(tail_idx) == head_idx) begin
               push_beat(cqf_pkg::STATUS_FULL, '0, 1'b1);
            end else begin
               slot_mem[tail_idx] = data;
               tail_idx           = next_idx(tail_idx);
               push_beat(cqf_pkg::STATUS_OK, '0, 1'b1);
            end
         end
         cqf_pkg::CMD_DEQUEUE: begin
            if (was_empty) begin
               push_beat(cqf_pkg::STATUS_EMPTY, '0, 1'b1);
            end else begin
               idx      = head_idx;
               head_idx = next_idx(head_idx);
               push_beat(cqf_pkg::STATUS_OK, slot_mem[idx], 1'b1);
            end
         end
         cqf_pkg::CMD_PEEK: begin
            if (was_empty) push_beat(cqf_pkg::STATUS_EMPTY, '0, 1'b1);
            else           push_beat(cqf_pkg::STATUS_OK, slot_mem[head_idx], 1'b1);
         end
         cqf_pkg::CMD_CLEAR: begin
            tail_idx = head_idx;
            push_beat(cqf_pkg::STATUS_OK, '0, 1'b1);
         end
         cqf_pkg::CMD_TRAVERSE: begin
            if (was_empty) begin
               push_beat(cqf_pkg::STATUS_EMPTY, '0, 1'b1);
            end else begin
               idx = head_idx;
               while (idx != tail_idx) begin
                  push_beat(cqf_pkg::STATUS_OK, slot_mem[idx], next_idx(idx) == tail_idx);
                  idx = next_idx(idx);
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head_idx = 0;
         tail_idx = 0;
         awaited_rsp.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_beat.status = cqf_pkg::status_type'(rsp_tuser[STATUS_W-1:0]);
            got_beat.empty  = rsp_tuser[STATUS_W];
            got_beat.value  = rsp_tdata[DATA_W-1:0];
            got_beat.fill   = rsp_tdata[DATA_W +: FILL_W];
            got_beat.last   = rsp_tlast;
            beats_seen++;
            if (awaited_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected rsp beat status=%0d value=%h fill=%0d ",
                           $realtime, got_beat.status, got_beat.value, got_beat.fill,
                           "empty=%b last=%b", got_beat.empty, got_beat.last);
            end else begin
               want_beat = awaited_rsp.pop_front();
               if (want_beat.status !== got_beat.status ||
                   want_beat.value !== got_beat.value ||
                   want_beat.fill !== got_beat.fill || want_beat.empty !== got_beat.empty ||
                   want_beat.last !== got_beat.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: rsp mismatch want status=%0d value=%h fill=%0d ",
                              $realtime, want_beat.status, want_beat.value, want_beat.fill,
                              "empty=%b last=%b, ", want_beat.empty, want_beat.last,
                              "got status=%0d value=%h fill=%0d ",
                              got_beat.status, got_beat.value, got_beat.fill,
                              "empty=%b last=%b", got_beat.empty, got_beat.last);
               end
            end
         end
         if (req_tvalid && req_tready) run_command(req_tuser, req_tdata);
      end
      error_count   <= mismatches;
      pending_count <= awaited_rsp.size();
      beat_count    <= beats_seen;
   end

endmodule

// ===== dv/circular_queue_fifo_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_queue_fifo_top_tb
// Drives commands into the ring-buffer queue and lets the checker judge the
// responses. A directed opening covers empty and full queues, extreme words,
// index wrap, clear and the unused command codes; random commands follow,
// alternating between filling and draining, with random gaps on the command
// side and random stalls on the response side.
// ----------------------------------------------------------------------------
module circular_queue_fifo_top_tb;

   localparam int          CMD_W        = cqf_pkg::CMD_W;
   localparam int          DATA_W       = cqf_pkg::DATA_W;
   localparam int          SLOTS        = 16;
   localparam int          RANDOM_ITEMS = 170;
   localparam int unsigned CYCLE_LIMIT  = 600_000;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser  = '0;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [2:0]  rsp_tuser;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   int          error_count;
   int          pending_count;
   int          beat_count;

   int unsigned cycle_count = 0;
   int          rx_hold     = 0;
   bit          rx_steady   = 1'b0;
   bit          tx_steady   = 1'b0;
   bit          filling     = 1'b1;
   bit          mid_pause_done;
   int          real_items;
   int          sent_total;
   int          mode_left;
   int          sent_by_cmd [1 << CMD_W];
   logic [CMD_W-1:0]  next_cmd;
   logic [DATA_W-1:0] corner_words [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};

   circular_queue_fifo_top #(.SLOTS(SLOTS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   circular_queue_fifo_checker #(.SLOTS(SLOTS)) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tuser     (rsp_tuser),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .error_count   (error_count),
      .pending_count (pending_count),
      .beat_count    (beat_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached, %0d beats still awaited", $realtime, pending_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   // stall the response side: mostly short holds, a few long, some steady stretches
   always @(posedge clock) begin
      if (cycle_count % 64 == 0) rx_steady <= ($urandom_range(0, 3) == 0);
      if (rx_hold != 0) begin
         rsp_tready <= 1'b0;
         rx_hold    <= rx_hold - 1;
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         rx_hold    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (tx_steady || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [DATA_W-1:0] pick_word();
      if ($urandom_range(0, 7) == 0) return corner_words[$urandom_range(0, 3)];
      return $urandom;
   endfunction

   function automatic logic [CMD_W-1:0] pick_command(input bit fill_bias);
      int unsigned r;
      int unsigned enq_w;
      int unsigned deq_w;
      r     = $urandom_range(0, 99);
      enq_w = fill_bias ? 55 : 20;
      deq_w = fill_bias ? 15 : 50;
      if (r < enq_w)              return cqf_pkg::CMD_ENQUEUE;
      if (r < enq_w + deq_w)      return cqf_pkg::CMD_DEQUEUE;
      if (r < enq_w + deq_w + 14) return cqf_pkg::CMD_PEEK;
      if (r < enq_w + deq_w + 24) return cqf_pkg::CMD_TRAVERSE;
      if (r < enq_w + deq_w + 27) return cqf_pkg::CMD_CLEAR;
      return CMD_W'($urandom_range(int'(cqf_pkg::CMD_TRAVERSE) + 1, (1 << CMD_W) - 1));
   endfunction

   // hold the beat until accepted, then idle for a random gap
   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] data);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      sent_by_cmd[cmd]++;
      sent_total++;
      if (sent_total % 20 == 0) tx_steady = ($urandom_range(0, 3) == 0);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      sent_total     = 0;
      real_items     = 0;
      mid_pause_done = 1'b0;
      mode_left      = $urandom_range(15, 40);
      foreach (sent_by_cmd[i]) sent_by_cmd[i] = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_beat(cqf_pkg::CMD_DEQUEUE, $urandom);
      send_beat(cqf_pkg::CMD_PEEK, $urandom);
      send_beat(cqf_pkg::CMD_TRAVERSE, $urandom);
      send_beat(cqf_pkg::CMD_ENQUEUE, 32'h8000_0000);
      send_beat(cqf_pkg::CMD_ENQUEUE, 32'h7fff_ffff);
      send_beat(cqf_pkg::CMD_PEEK, $urandom);
      send_beat(cqf_pkg::CMD_DEQUEUE, $urandom);
      // fill to capacity so the tail wraps past the last slot
      repeat (SLOTS - 2) send_beat(cqf_pkg::CMD_ENQUEUE, $urandom);
      send_beat(cqf_pkg::CMD_ENQUEUE, 32'hffff_ffff);
      send_beat(cqf_pkg::CMD_TRAVERSE, $urandom);
      send_beat(cqf_pkg::CMD_CLEAR, $urandom);
      for (int c = int'(cqf_pkg::CMD_TRAVERSE) + 1; c < (1 << CMD_W); c++)
         send_beat(CMD_W'(c), $urandom);
      send_beat(cqf_pkg::CMD_TRAVERSE, $urandom);

      while (real_items < RANDOM_ITEMS) begin
         if (mode_left == 0) begin
            filling   = !filling;
            mode_left = $urandom_range(15, 40);
         end
         mode_left--;
         if ((!mid_pause_done && real_items >= RANDOM_ITEMS / 2) ||
             $urandom_range(0, 99) == 0) begin
            mid_pause_done = 1'b1;
            wait_drained();
         end
         next_cmd = pick_command(filling);
         send_beat(next_cmd, pick_word());
         if (next_cmd <= cqf_pkg::CMD_TRAVERSE) real_items++;
      end

      wait_drained();
      repeat (20) @(posedge clock);

      $display("covered %0d commands: enq %0d, deq %0d, peek %0d, clear %0d, trav %0d, ",
               sent_total, sent_by_cmd[cqf_pkg::CMD_ENQUEUE],
               sent_by_cmd[cqf_pkg::CMD_DEQUEUE], sent_by_cmd[cqf_pkg::CMD_PEEK],
               sent_by_cmd[cqf_pkg::CMD_CLEAR], sent_by_cmd[cqf_pkg::CMD_TRAVERSE],
               "unused %0d",
               sent_total - sent_by_cmd[cqf_pkg::CMD_ENQUEUE] -
               sent_by_cmd[cqf_pkg::CMD_DEQUEUE] - sent_by_cmd[cqf_pkg::CMD_PEEK] -
               sent_by_cmd[cqf_pkg::CMD_CLEAR] - sent_by_cmd[cqf_pkg::CMD_TRAVERSE]);
      $display("checked %0d response beats, %0d errors", beat_count, error_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
